// ----- hdl/ir_pulse_frame_decoder_top_defines.svh -----
// Assertion macros for the checker file irpfd_checker.sv.
`ifndef IR_PULSE_FRAME_DECODER_TOP_DEFINES_SVH
`define IR_PULSE_FRAME_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define IRPFD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("irpfd assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define IRPFD_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("irpfd assertion failed");

`endif

// ----- hdl/irpfd_pkg.sv -----
`default_nettype none

package irpfd_pkg;

	localparam int unsigned WidthW = 16;

	typedef enum logic [2:0] {
		REG_MARK_MIN = 3'd0,
		REG_MARK_MAX = 3'd1,
		REG_ZERO_MIN = 3'd2,
		REG_ZERO_MAX = 3'd3,
		REG_ONE_MIN  = 3'd4,
		REG_ONE_MAX  = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		FAULT_LEADER = 2'd0,
		FAULT_MARK   = 2'd1,
		FAULT_SPACE  = 2'd2,
		FAULT_COMPL  = 2'd3
	} fault_kind_t;

	localparam logic [15:0] LEAD0_MIN = 16'd28000;
	localparam logic [15:0] LEAD0_MAX = 16'd31000;
	localparam logic [15:0] LEAD1_MIN = 16'd48000;
	localparam logic [15:0] LEAD1_MAX = 16'd51000;
	localparam logic [15:0] LEAD2_MIN = 16'd3300;
	localparam logic [15:0] LEAD2_MAX = 16'd3500;
	localparam logic [15:0] LEAD3_MIN = 16'd1600;
	localparam logic [15:0] LEAD3_MAX = 16'd1700;

	localparam logic [15:0] MARK_MIN_RST = 16'd400;
	localparam logic [15:0] MARK_MAX_RST = 16'd470;
	localparam logic [15:0] ZERO_MIN_RST = 16'd390;
	localparam logic [15:0] ZERO_MAX_RST = 16'd450;
	localparam logic [15:0] ONE_MIN_RST  = 16'd1230;
	localparam logic [15:0] ONE_MAX_RST  = 16'd1290;

	typedef struct packed {
		logic [15:0] mark_min;
		logic [15:0] mark_max;
		logic [15:0] zero_min;
		logic [15:0] zero_max;
		logic [15:0] one_min;
		logic [15:0] one_max;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  byte_value;
		logic [5:0]  byte_position;
		logic        frame_end;
		logic        fault;
		fault_kind_t fault_kind;
	} res_t;

	function automatic logic in_win(logic [15:0] w, logic [15:0] lo, logic [15:0] hi);
		return (w >= lo) && (w <= hi);
	endfunction

endpackage

`default_nettype wire

// ----- hdl/irpfd_if.sv -----
`default_nettype none

interface irpfd_sym_if;
	logic        valid;
	logic        ready;
	logic        level;
	logic [15:0] width_us;

	modport source (output valid, level, width_us, input ready);
	modport sink (input valid, level, width_us, output ready);
endinterface

interface irpfd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic [5:0] byte_position;
	logic       frame_end;
	logic       fault;
	logic [1:0] fault_kind;

	modport source (output valid, byte_value, byte_position, frame_end, fault, fault_kind,
		input ready);
	modport sink (input valid, byte_value, byte_position, frame_end, fault, fault_kind,
		output ready);
endinterface

`default_nettype wire

// ----- hdl/irpfd_cfg.sv -----
`default_nettype none

module irpfd_cfg (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [4:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output irpfd_pkg::cfg_t   cfg
);
	import irpfd_pkg::*;

	cfg_t     regs_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[4:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.mark_min <= MARK_MIN_RST;
			regs_q.mark_max <= MARK_MAX_RST;
			regs_q.zero_min <= ZERO_MIN_RST;
			regs_q.zero_max <= ZERO_MAX_RST;
			regs_q.one_min  <= ONE_MIN_RST;
			regs_q.one_max  <= ONE_MAX_RST;
		end else if (wr) begin
			case (idx)
				REG_MARK_MIN: regs_q.mark_min <= pwdata[15:0];
				REG_MARK_MAX: regs_q.mark_max <= pwdata[15:0];
				REG_ZERO_MIN: regs_q.zero_min <= pwdata[15:0];
				REG_ZERO_MAX: regs_q.zero_max <= pwdata[15:0];
				REG_ONE_MIN:  regs_q.one_min  <= pwdata[15:0];
				REG_ONE_MAX:  regs_q.one_max  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MARK_MIN: prdata = {16'd0, regs_q.mark_min};
			REG_MARK_MAX: prdata = {16'd0, regs_q.mark_max};
			REG_ZERO_MIN: prdata = {16'd0, regs_q.zero_min};
			REG_ZERO_MAX: prdata = {16'd0, regs_q.zero_max};
			REG_ONE_MIN:  prdata = {16'd0, regs_q.one_min};
			REG_ONE_MAX:  prdata = {16'd0, regs_q.one_max};
			default:      prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

// ----- hdl/irpfd_decode.sv -----
`default_nettype none

module irpfd_decode #(
	parameter int unsigned FRAME_BYTES  = 53,
	parameter int unsigned HEADER_BYTES = 3
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            level,
	input  wire logic [15:0]     width_us,
	input  wire irpfd_pkg::cfg_t cfg,
	output logic                 res_valid,
	output irpfd_pkg::res_t      res
);
	import irpfd_pkg::*;

	localparam logic [5:0] EndCount = 6'(FRAME_BYTES % 64);
	localparam logic [5:0] HdrCount = 6'(HEADER_BYTES);

	logic [2:0] leader_q, leader_d;
	logic [5:0] byte_cnt_q, byte_cnt_d;
	logic [7:0] shift_q, shift_d;
	logic [2:0] bit_cnt_q, bit_cnt_d;
	logic       exp_space_q, exp_space_d;
	logic       comp_next_q, comp_next_d;
	logic [7:0] prior_q, prior_d;
	logic       halted_q, halted_d;

	logic       lead_ok, is_zero, is_one;
	logic [7:0] new_byte;
	logic [5:0] next_cnt;

	always_comb begin
		leader_d    = leader_q;
		byte_cnt_d  = byte_cnt_q;
		shift_d     = shift_q;
		bit_cnt_d   = bit_cnt_q;
		exp_space_d = exp_space_q;
		comp_next_d = comp_next_q;
		prior_d     = prior_q;
		halted_d    = halted_q;
		res_valid   = 1'b0;
		res         = '{byte_value: 8'd0, byte_position: byte_cnt_q, frame_end: 1'b0,
			fault: 1'b1, fault_kind: FAULT_LEADER};

		case (leader_q[1:0])
			2'd0:    lead_ok = !level && in_win(width_us, LEAD0_MIN, LEAD0_MAX);
			2'd1:    lead_ok = level && in_win(width_us, LEAD1_MIN, LEAD1_MAX);
			2'd2:    lead_ok = !level && in_win(width_us, LEAD2_MIN, LEAD2_MAX);
			default: lead_ok = level && in_win(width_us, LEAD3_MIN, LEAD3_MAX);
		endcase
		is_zero  = level && in_win(width_us, cfg.zero_min, cfg.zero_max);
		is_one   = level && !is_zero && in_win(width_us, cfg.one_min, cfg.one_max);
		new_byte = shift_q | (8'(is_one) << bit_cnt_q);
		next_cnt = byte_cnt_q + 6'd1;

		if (halted_q) begin
			res_valid = 1'b0;
		end else if (!leader_q[2]) begin
			if (leader_q == 3'd0 && level) begin
				res_valid = 1'b0;
			end else if (!lead_ok) begin
				halted_d  = 1'b1;
				res_valid = 1'b1;
			end else begin
				leader_d = leader_q + 3'd1;
			end
		end else if (!exp_space_q) begin
			if (!level && !in_win(width_us, cfg.mark_min, cfg.mark_max)) begin
				halted_d       = 1'b1;
				res_valid      = 1'b1;
				res.fault_kind = FAULT_MARK;
			end else begin
				exp_space_d = 1'b1;
			end
		end else if (!is_zero && !is_one) begin
			halted_d       = 1'b1;
			res_valid      = 1'b1;
			res.fault_kind = FAULT_SPACE;
		end else begin
			exp_space_d = 1'b0;
			if (bit_cnt_q != 3'd7) begin
				bit_cnt_d = bit_cnt_q + 3'd1;
				shift_d   = new_byte;
			end else begin
				shift_d   = 8'd0;
				bit_cnt_d = 3'd0;
				res_valid = 1'b1;
				if (byte_cnt_q >= HdrCount && comp_next_q && prior_q != ~new_byte) begin
					halted_d       = 1'b1;
					res.fault_kind = FAULT_COMPL;
				end else begin
					if (byte_cnt_q >= HdrCount) begin
						if (!comp_next_q)
							prior_d = new_byte;
						comp_next_d = !comp_next_q;
					end
					res.byte_value = new_byte;
					res.fault      = 1'b0;
					res.frame_end  = (next_cnt == EndCount);
					byte_cnt_d     = next_cnt;
					if (next_cnt == EndCount) begin
						byte_cnt_d  = 6'd0;
						leader_d    = 3'd0;
						comp_next_d = 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leader_q    <= 3'd0;
			byte_cnt_q  <= 6'd0;
			shift_q     <= 8'd0;
			bit_cnt_q   <= 3'd0;
			exp_space_q <= 1'b0;
			comp_next_q <= 1'b0;
			halted_q    <= 1'b0;
		end else if (en) begin
			leader_q    <= leader_d;
			byte_cnt_q  <= byte_cnt_d;
			shift_q     <= shift_d;
			bit_cnt_q   <= bit_cnt_d;
			exp_space_q <= exp_space_d;
			comp_next_q <= comp_next_d;
			halted_q    <= halted_d;
		end
	end

	// data byte kept for the complement check; read only after a write
	always_ff @(posedge clk) begin
		if (en)
			prior_q <= prior_d;
	end

endmodule

`default_nettype wire

// ----- hdl/ir_pulse_frame_decoder_top.sv -----
// IR pulse-distance frame decoder. Each sym beat is one line symbol (level, width in us);
// a four-symbol leader is checked against fixed windows, then mark/space pairs give bits
// LSB first, and every finished byte leaves as one rx beat, with frame_end on the last
// byte of the frame. A leader, mark, space or complement error gives one rx beat with
// fault set and fault_kind, after which every symbol is dropped until reset. One symbol
// is taken per clock while rx is not stalled; the input register takes the symbol,
// the window compares and shift run on it from that register, and the result
// register holds the outcome that shows on rx.
// The six timing windows sit in APB registers 0 to 5 at byte addresses 0x00 to 0x14 and
// should be written while no symbol is in flight.
`default_nettype none

module ir_pulse_frame_decoder_top #(
	parameter int unsigned FRAME_BYTES  = 53,
	parameter int unsigned HEADER_BYTES = 3
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	irpfd_sym_if.sink        sym,
	irpfd_byte_if.source     rx
);
	import irpfd_pkg::*;

	cfg_t        cfg;
	logic        v_s1, level_s1;
	logic [15:0] width_s1;
	logic        out_v_q;
	res_t        res_q, res;
	logic        res_valid, proc;

	assign proc      = v_s1 && (!out_v_q || rx.ready);
	assign sym.ready = !v_s1 || proc;

	irpfd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	irpfd_decode #(
		.FRAME_BYTES  (FRAME_BYTES),
		.HEADER_BYTES (HEADER_BYTES)
	) u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (proc),
		.level     (level_s1),
		.width_us  (width_s1),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (sym.ready)
				v_s1 <= sym.valid;
			if (proc)
				out_v_q <= res_valid;
			else if (rx.ready)
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sym.ready) begin
			level_s1 <= sym.level;
			width_s1 <= sym.width_us;
		end
		if (proc && res_valid)
			res_q <= res;
	end

	assign rx.valid         = out_v_q;
	assign rx.byte_value    = res_q.byte_value;
	assign rx.byte_position = res_q.byte_position;
	assign rx.frame_end     = res_q.frame_end;
	assign rx.fault         = res_q.fault;
	assign rx.fault_kind    = res_q.fault_kind;

endmodule

`default_nettype wire

// ----- hdl/irpfd_checker.sv -----
`default_nettype none
`include "ir_pulse_frame_decoder_top_defines.svh"

module irpfd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       rx_valid,
	input wire logic       rx_ready,
	input wire logic [7:0] rx_byte_value,
	input wire logic       rx_frame_end,
	input wire logic       rx_fault,
	input wire logic [1:0] rx_fault_kind
);
	import irpfd_pkg::*;

	`IRPFD_ASSERT_IMP(a_fault_clean, rx_valid && rx_fault, rx_byte_value == 8'd0 && !rx_frame_end)
	`IRPFD_ASSERT_IMP(a_kind_zero, rx_valid && !rx_fault, rx_fault_kind == FAULT_LEADER)
	`IRPFD_ASSERT_NXT(a_halt_silent, rx_valid && rx_ready && rx_fault, !rx_valid)
	`IRPFD_ASSERT_NXT(a_hold, rx_valid && !rx_ready, rx_valid && $stable(rx_byte_value))

endmodule

bind ir_pulse_frame_decoder_top irpfd_checker u_irpfd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rx_valid      (rx.valid),
	.rx_ready      (rx.ready),
	.rx_byte_value (rx.byte_value),
	.rx_frame_end  (rx.frame_end),
	.rx_fault      (rx.fault),
	.rx_fault_kind (rx.fault_kind)
);

`default_nettype wire
